/* rtl/itpc_pkg.sv */
`timescale 1ns / 1ps

package itpc_pkg;

  typedef enum logic [2:0] {
    CLS_NONE     = 3'd0,
    CLS_OPERAND  = 3'd1,
    CLS_OPERATOR = 3'd2,
    CLS_OPEN     = 3'd3,
    CLS_CLOSE    = 3'd4
  } cls_t;

  typedef enum logic [2:0] {
    OPC_NONE = 3'd0,
    OPC_OPEN = 3'd1,
    OPC_ADD  = 3'd2,
    OPC_SUB  = 3'd3,
    OPC_MUL  = 3'd4,
    OPC_DIV  = 3'd5
  } opc_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CLOSE_POP,
    S_OP_POP,
    S_FINISH,
    S_FLUSH,
    S_CLOSE_RES
  } state_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_MUL   = 8'h2A;
  localparam logic [7:0] CHAR_ADD   = 8'h2B;
  localparam logic [7:0] CHAR_SUB   = 8'h2D;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;

  // status from datapath to controller
  typedef struct packed {
    logic err_set;
    logic is_space;
    logic bad;
    cls_t cls;
    logic eoe;
    logic stack_empty;
    logic top_is_open;
    logic op_stops;
    logic out_free;
  } itpc_stat_t;

  // commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic latch;
    logic commit;
    logic set_invalid;
    logic push;
    logic emit_letter;
    logic pop_emit;
    logic pop_drop;
    logic end_check;
    logic emit_close;
  } itpc_cmd_t;

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_NONE;
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
      r = CLS_OPERAND;
    end else if (c == CHAR_ADD || c == CHAR_SUB || c == CHAR_MUL || c == CHAR_DIV) begin
      r = CLS_OPERATOR;
    end else if (c == CHAR_OPEN) begin
      r = CLS_OPEN;
    end else if (c == CHAR_CLOSE) begin
      r = CLS_CLOSE;
    end
    return r;
  endfunction

  function automatic opc_t code_of(input logic [7:0] c);
    opc_t r;
    case (c)
      CHAR_ADD:  r = OPC_ADD;
      CHAR_SUB:  r = OPC_SUB;
      CHAR_MUL:  r = OPC_MUL;
      CHAR_DIV:  r = OPC_DIV;
      CHAR_OPEN: r = OPC_OPEN;
      default:   r = OPC_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] char_of(input opc_t o);
    logic [7:0] r;
    unique case (o)
      OPC_OPEN: r = CHAR_OPEN;
      OPC_ADD:  r = CHAR_ADD;
      OPC_SUB:  r = CHAR_SUB;
      OPC_MUL:  r = CHAR_MUL;
      OPC_DIV:  r = CHAR_DIV;
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic prec_of(input opc_t o);
    return (o == OPC_MUL || o == OPC_DIV);
  endfunction

  function automatic logic order_ok(input cls_t cls, input cls_t prev, input logic seen);
    logic r;
    if (!seen) begin
      r = (cls == CLS_OPERAND || cls == CLS_OPEN);
    end else begin
      unique case (cls)
        CLS_OPERATOR: r = !(prev == CLS_OPERATOR || prev == CLS_OPEN);
        CLS_OPERAND:  r = !(prev == CLS_OPERAND || prev == CLS_CLOSE);
        CLS_OPEN:     r = !(prev == CLS_CLOSE || prev == CLS_OPERAND);
        CLS_CLOSE:    r = (prev != CLS_OPEN);
        default:      r = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/itpc_if.sv */
`timescale 1ns / 1ps

interface itpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_expression;

  modport source (output valid, character, end_of_expression, input ready);
  modport sink (input valid, character, end_of_expression, output ready);
endinterface

interface itpc_out_if;
  logic       valid;
  logic       ready;
  logic       token_present;
  logic [7:0] token;
  logic       end_of_result;
  logic [1:0] status;

  modport source (output valid, token_present, token, end_of_result, status, input ready);
  modport sink (input valid, token_present, token, end_of_result, status, output ready);
endinterface

/* rtl/itpc_ram.sv */
`timescale 1ns / 1ps

module itpc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/itpc_ctrl.sv */
`timescale 1ns / 1ps

module itpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  input  itpc_pkg::itpc_stat_t stat,
  output itpc_pkg::itpc_cmd_t  cmd
);

  itpc_pkg::state_t state, state_next;
  itpc_pkg::state_t char_done;

  assign char_done = stat.eoe ? itpc_pkg::S_FINISH : itpc_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itpc_pkg::S_IDLE: begin
        if (char_valid) state_next = itpc_pkg::S_EVAL;
      end
      itpc_pkg::S_EVAL: begin
        if (stat.err_set || stat.is_space || stat.bad) begin
          state_next = char_done;
        end else begin
          unique case (stat.cls)
            itpc_pkg::CLS_OPERAND:  if (stat.out_free) state_next = char_done;
            itpc_pkg::CLS_OPEN:     state_next = char_done;
            itpc_pkg::CLS_CLOSE:    state_next = itpc_pkg::S_CLOSE_POP;
            itpc_pkg::CLS_OPERATOR: state_next = itpc_pkg::S_OP_POP;
            default:                state_next = char_done;
          endcase
        end
      end
      itpc_pkg::S_CLOSE_POP: begin
        if (stat.stack_empty || stat.top_is_open) state_next = char_done;
      end
      itpc_pkg::S_OP_POP: begin
        if (stat.stack_empty || stat.op_stops) state_next = char_done;
      end
      itpc_pkg::S_FINISH: state_next = itpc_pkg::S_FLUSH;
      itpc_pkg::S_FLUSH: begin
        if (stat.err_set || stat.stack_empty) state_next = itpc_pkg::S_CLOSE_RES;
      end
      itpc_pkg::S_CLOSE_RES: begin
        if (stat.out_free) state_next = itpc_pkg::S_IDLE;
      end
      default: state_next = itpc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      itpc_pkg::S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.latch    = char_valid;
      end
      itpc_pkg::S_EVAL: begin
        if (!(stat.err_set || stat.is_space)) begin
          if (stat.bad) begin
            cmd.set_invalid = 1'b1;
          end else begin
            unique case (stat.cls) inside
              itpc_pkg::CLS_OPERAND: begin
                cmd.commit      = stat.out_free;
                cmd.emit_letter = stat.out_free;
              end
              itpc_pkg::CLS_OPEN: begin
                cmd.commit = 1'b1;
                cmd.push   = 1'b1;
              end
              itpc_pkg::CLS_CLOSE,
              itpc_pkg::CLS_OPERATOR: cmd.commit = 1'b1;
              default: ;
            endcase
          end
        end
      end
      itpc_pkg::S_CLOSE_POP: begin
        if (!stat.stack_empty) begin
          if (stat.top_is_open) cmd.pop_drop = 1'b1;
          else                  cmd.pop_emit = stat.out_free;
        end
      end
      itpc_pkg::S_OP_POP: begin
        if (stat.stack_empty || stat.op_stops) cmd.push = 1'b1;
        else                                   cmd.pop_emit = stat.out_free;
      end
      itpc_pkg::S_FINISH: cmd.end_check = 1'b1;
      itpc_pkg::S_FLUSH: begin
        if (!stat.err_set && !stat.stack_empty) cmd.pop_emit = stat.out_free;
      end
      itpc_pkg::S_CLOSE_RES: cmd.emit_close = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/itpc_datapath.sv */
`timescale 1ns / 1ps

module itpc_datapath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          character,
  input  logic                end_of_expression,
  input  itpc_pkg::itpc_cmd_t  cmd,
  output itpc_pkg::itpc_stat_t stat,
  output logic                res_valid,
  input  logic                res_ready,
  output logic                res_token_present,
  output logic [7:0]          res_token,
  output logic                res_end_of_result,
  output logic [1:0]          res_status
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int BAL_W  = $clog2(STACK_DEPTH + 2);

  logic [7:0]         char_reg;
  logic               eoe_reg;
  logic [CNT_W-1:0]   count, count_next, count_dec;
  logic [BAL_W-1:0]   balance;
  itpc_pkg::cls_t     prev_class;
  logic               seen_first;
  itpc_pkg::status_t  error_code;

  itpc_pkg::cls_t     cls;
  itpc_pkg::opc_t     char_code, top_code;
  logic               full, push_ok, out_free, out_load;
  logic [ADDR_W-1:0]  rd_addr;
  logic [2:0]         rd_data;

  assign cls       = itpc_pkg::classify(char_reg);
  assign char_code = itpc_pkg::code_of(char_reg);
  assign top_code  = itpc_pkg::opc_t'(rd_data);
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign push_ok   = cmd.push && !full;
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    stat.err_set     = (error_code != itpc_pkg::ST_OK);
    stat.is_space    = (char_reg == itpc_pkg::CHAR_SPACE);
    stat.bad         = (cls == itpc_pkg::CLS_NONE) ||
                       (cls == itpc_pkg::CLS_CLOSE && balance == '0) ||
                       !itpc_pkg::order_ok(cls, prev_class, seen_first);
    stat.cls         = cls;
    stat.eoe         = eoe_reg;
    stat.stack_empty = (count == '0);
    stat.top_is_open = (top_code == itpc_pkg::OPC_OPEN);
    stat.op_stops    = (top_code == itpc_pkg::OPC_OPEN) ||
                       (itpc_pkg::prec_of(char_code) && !itpc_pkg::prec_of(top_code));
    stat.out_free    = out_free;
  end

  // stack depth, read address tracks the top of the next cycle
  always_comb begin
    count_next = count;
    if (cmd.emit_close) begin
      count_next = '0;
    end else if (push_ok) begin
      count_next = count + 1'b1;
    end else if (cmd.pop_emit || cmd.pop_drop) begin
      count_next = count - 1'b1;
    end
  end

  assign count_dec = count_next - 1'b1;
  assign rd_addr   = (count_next == '0) ? '0 : count_dec[ADDR_W-1:0];

  itpc_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ((cls == itpc_pkg::CLS_OPEN) ? itpc_pkg::OPC_OPEN : char_code),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_reg <= character;
      eoe_reg  <= end_of_expression;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      balance    <= '0;
      prev_class <= itpc_pkg::CLS_NONE;
      seen_first <= 1'b0;
      error_code <= itpc_pkg::ST_OK;
    end else begin
      count <= count_next;
      if (cmd.emit_close) begin
        balance    <= '0;
        prev_class <= itpc_pkg::CLS_NONE;
        seen_first <= 1'b0;
        error_code <= itpc_pkg::ST_OK;
      end else begin
        if (cmd.commit) begin
          prev_class <= cls;
          seen_first <= 1'b1;
          if (cls == itpc_pkg::CLS_OPEN)  balance <= balance + 1'b1;
          if (cls == itpc_pkg::CLS_CLOSE) balance <= balance - 1'b1;
        end
        if (cmd.set_invalid) begin
          error_code <= itpc_pkg::ST_INVALID;
        end else if (cmd.push && full) begin
          error_code <= itpc_pkg::ST_OVERFLOW;
        end else if (cmd.end_check && error_code == itpc_pkg::ST_OK &&
                     (balance != '0 || prev_class == itpc_pkg::CLS_OPERATOR ||
                      prev_class == itpc_pkg::CLS_OPEN)) begin
          error_code <= itpc_pkg::ST_INVALID;
        end
      end
    end
  end

  // output register
  assign out_load = cmd.emit_letter || cmd.pop_emit || cmd.emit_close;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_token_present <= !cmd.emit_close;
      res_end_of_result <= cmd.emit_close;
      res_status        <= cmd.emit_close ? error_code : itpc_pkg::ST_OK;
      if (cmd.emit_letter)   res_token <= char_reg;
      else if (cmd.pop_emit) res_token <= itpc_pkg::char_of(top_code);
      else                   res_token <= 8'h00;
    end
  end

endmodule

/* rtl/infix_to_postfix_converter_unit.sv */
`timescale 1ns / 1ps

// channel  dir  payload                                       transfer
// expr     in   character[7:0], end_of_expression             valid && ready
// postfix  out  token_present, token[7:0], end_of_result,     valid && ready
//               status[1:0]
//
// one character at a time: each is latched in idle and then evaluated; ')' and
// operators go on to pop operators off the stack until the stop condition
// the last character adds a finish step, a flush that pops the operators left on
// the stack until it is empty, and the closing result
// rst is synchronous and clears the controller, the stack depth and the checks
// a stalled postfix holds the controller wherever it wants to emit

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  itpc_in_if.sink           expr,
  itpc_out_if.source        postfix
);

  itpc_pkg::itpc_cmd_t  cmd;
  itpc_pkg::itpc_stat_t stat;

  // ready only while the controller waits for a new character
  assign expr.ready = cmd.in_ready;

  // sequencer: one character walked through eval and the pop loops
  itpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (expr.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  // operator stack, validity checks and the output register
  itpc_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .character         (expr.character),
    .end_of_expression (expr.end_of_expression),
    .cmd               (cmd),
    .stat              (stat),
    .res_valid         (postfix.valid),
    .res_ready         (postfix.ready),
    .res_token_present (postfix.token_present),
    .res_token         (postfix.token),
    .res_end_of_result (postfix.end_of_result),
    .res_status        (postfix.status)
  );

endmodule

/* tb/infix_to_postfix_converter_unit_tb.sv */
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;

  localparam int DEPTH        = 32;
  localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 60;    // settle time after the last result

  // one postfix result as seen on the output channel
  typedef struct packed {
    logic       token_present;
    logic [7:0] token;
    logic       end_of_result;
    logic [1:0] status;
  } postfix_item_t;

  logic clk = 1'b0;
  logic rst;

  itpc_in_if  expr_in ();
  itpc_out_if postfix_out ();

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr_in),
    .postfix(postfix_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle chances in percent per cycle, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  int chars_sent       = 0;
  int mismatch_count   = 0;
  bit hold_active      = 1'b0;
  event hold_start;

  postfix_item_t expected_postfix[$];
  logic [7:0]    expr_buf[$];

  // predictor state: operator stack, ordering checks and sticky fault
  itpc_pkg::opc_t    pending_ops [DEPTH];
  int unsigned       pending_depth = 0;
  itpc_pkg::cls_t    prev_kind     = itpc_pkg::CLS_NONE;
  int unsigned       open_parens   = 0;
  bit                any_symbol    = 1'b0;
  itpc_pkg::status_t expr_fault    = itpc_pkg::ST_OK;

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  function automatic itpc_pkg::cls_t char_kind(input logic [7:0] c,
                                               output itpc_pkg::opc_t code);
    code = itpc_pkg::OPC_NONE;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return itpc_pkg::CLS_OPERAND;
    case (c)
      itpc_pkg::CHAR_ADD: begin
        code = itpc_pkg::OPC_ADD;
        return itpc_pkg::CLS_OPERATOR;
      end
      itpc_pkg::CHAR_SUB: begin
        code = itpc_pkg::OPC_SUB;
        return itpc_pkg::CLS_OPERATOR;
      end
      itpc_pkg::CHAR_MUL: begin
        code = itpc_pkg::OPC_MUL;
        return itpc_pkg::CLS_OPERATOR;
      end
      itpc_pkg::CHAR_DIV: begin
        code = itpc_pkg::OPC_DIV;
        return itpc_pkg::CLS_OPERATOR;
      end
      itpc_pkg::CHAR_OPEN: begin
        code = itpc_pkg::OPC_OPEN;
        return itpc_pkg::CLS_OPEN;
      end
      itpc_pkg::CHAR_CLOSE: return itpc_pkg::CLS_CLOSE;
      default:              return itpc_pkg::CLS_NONE;
    endcase
  endfunction

  function automatic bit binds_tight(input itpc_pkg::opc_t o);
    return o == itpc_pkg::OPC_MUL || o == itpc_pkg::OPC_DIV;
  endfunction

  // may a symbol of this kind follow what came before it
  function automatic bit follows_legally(input itpc_pkg::cls_t kind);
    if (!any_symbol) return kind == itpc_pkg::CLS_OPERAND || kind == itpc_pkg::CLS_OPEN;
    case (kind)
      itpc_pkg::CLS_OPERATOR:
        return !(prev_kind == itpc_pkg::CLS_OPERATOR || prev_kind == itpc_pkg::CLS_OPEN);
      itpc_pkg::CLS_OPERAND:
        return !(prev_kind == itpc_pkg::CLS_OPERAND || prev_kind == itpc_pkg::CLS_CLOSE);
      itpc_pkg::CLS_OPEN:
        return !(prev_kind == itpc_pkg::CLS_CLOSE || prev_kind == itpc_pkg::CLS_OPERAND);
      itpc_pkg::CLS_CLOSE:
        return prev_kind != itpc_pkg::CLS_OPEN;
      default:
        return 1'b0;
    endcase
  endfunction

  function automatic void queue_token(input logic [7:0] tok);
    expected_postfix.push_back('{1'b1, tok, 1'b0, itpc_pkg::ST_OK});
  endfunction

  function automatic void pop_to_output();
    logic [7:0] glyph;
    pending_depth--;
    case (pending_ops[pending_depth])
      itpc_pkg::OPC_ADD:  glyph = itpc_pkg::CHAR_ADD;
      itpc_pkg::OPC_SUB:  glyph = itpc_pkg::CHAR_SUB;
      itpc_pkg::OPC_MUL:  glyph = itpc_pkg::CHAR_MUL;
      itpc_pkg::OPC_DIV:  glyph = itpc_pkg::CHAR_DIV;
      itpc_pkg::OPC_OPEN: glyph = itpc_pkg::CHAR_OPEN;
      default:            glyph = 8'h00;
    endcase
    queue_token(glyph);
  endfunction

  function automatic void push_op(input itpc_pkg::opc_t code);
    if (pending_depth >= DEPTH) begin
      expr_fault = itpc_pkg::ST_OVERFLOW;
    end else begin
      pending_ops[pending_depth] = code;
      pending_depth++;
    end
  endfunction

  // works out the results that one accepted character causes
  function automatic void predict_postfix(input logic [7:0] c, input logic eoe);
    itpc_pkg::cls_t kind;
    itpc_pkg::opc_t code;
    if (expr_fault == itpc_pkg::ST_OK && c != itpc_pkg::CHAR_SPACE) begin
      kind = char_kind(c, code);
      if (kind == itpc_pkg::CLS_NONE ||
          (kind == itpc_pkg::CLS_CLOSE && open_parens == 0) ||
          !follows_legally(kind)) begin
        expr_fault = itpc_pkg::ST_INVALID;
      end else begin
        any_symbol = 1'b1;
        prev_kind  = kind;
        case (kind)
          itpc_pkg::CLS_OPERAND: queue_token(c);
          itpc_pkg::CLS_OPEN: begin
            open_parens++;
            push_op(itpc_pkg::OPC_OPEN);
          end
          itpc_pkg::CLS_CLOSE: begin
            open_parens--;
            while (pending_depth > 0 &&
                   pending_ops[pending_depth-1] != itpc_pkg::OPC_OPEN)
              pop_to_output();
            if (pending_depth > 0) pending_depth--;
          end
          default: begin
            // equal precedence pops first, a tighter operator stops the pops
            while (pending_depth > 0 &&
                   pending_ops[pending_depth-1] != itpc_pkg::OPC_OPEN &&
                   !(binds_tight(code) && !binds_tight(pending_ops[pending_depth-1])))
              pop_to_output();
            push_op(code);
          end
        endcase
      end
    end
    if (eoe) begin
      if (expr_fault == itpc_pkg::ST_OK &&
          (open_parens > 0 || prev_kind == itpc_pkg::CLS_OPERATOR ||
           prev_kind == itpc_pkg::CLS_OPEN))
        expr_fault = itpc_pkg::ST_INVALID;
      if (expr_fault == itpc_pkg::ST_OK) begin
        while (pending_depth > 0) pop_to_output();
      end
      expected_postfix.push_back('{1'b0, 8'h00, 1'b1, expr_fault});
      pending_depth = 0;
      prev_kind     = itpc_pkg::CLS_NONE;
      open_parens   = 0;
      any_symbol    = 1'b0;
      expr_fault    = itpc_pkg::ST_OK;
    end
  endfunction

  // ------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------

  // valid stays high from one transfer to the next unless an idle cycle is drawn
  task automatic send_char(input logic [7:0] c, input logic eoe);
    while ($urandom_range(99) < send_idle_pct) begin
      expr_in.valid <= 1'b0;
      @(posedge clk);
    end
    expr_in.valid             <= 1'b1;
    expr_in.character         <= c;
    expr_in.end_of_expression <= eoe;
    do @(posedge clk); while (!expr_in.ready);
    chars_sent++;
    predict_postfix(c, eoe);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < expr_buf.size(); i++) send_char(expr_buf[i], i == expr_buf.size() - 1);
  endtask

  // ------------------------------------------------------------------
  // expression generation
  // ------------------------------------------------------------------

  function automatic logic [7:0] random_letter();
    if ($urandom_range(1)) return 8'($urandom_range("z", "a"));
    return 8'($urandom_range("Z", "A"));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0: return itpc_pkg::CHAR_ADD;
      1: return itpc_pkg::CHAR_SUB;
      2: return itpc_pkg::CHAR_MUL;
      default: return itpc_pkg::CHAR_DIV;
    endcase
  endfunction

  task automatic maybe_space();
    if ($urandom_range(5) == 0) expr_buf.push_back(itpc_pkg::CHAR_SPACE);
  endtask

  task automatic build_operand(input int nest);
    maybe_space();
    if (nest > 0 && $urandom_range(2) == 0) begin
      expr_buf.push_back(itpc_pkg::CHAR_OPEN);
      build_sum(nest - 1);
      maybe_space();
      expr_buf.push_back(itpc_pkg::CHAR_CLOSE);
    end else begin
      expr_buf.push_back(random_letter());
    end
  endtask

  task automatic build_sum(input int nest);
    build_operand(nest);
    repeat ($urandom_range(3)) begin
      maybe_space();
      expr_buf.push_back(random_operator());
      build_operand(nest);
    end
    maybe_space();
  endtask

  // breaks a well-formed expression in one place
  task automatic damage_expression();
    int idx;
    idx = $urandom_range(expr_buf.size() - 1);
    case ($urandom_range(3))
      0: expr_buf[idx] = 8'($urandom_range(255));
      1: if (expr_buf.size() > 1) expr_buf.delete(idx);
      2: expr_buf[idx] = $urandom_range(1) ? random_operator()
                         : ($urandom_range(1) ? itpc_pkg::CHAR_OPEN : itpc_pkg::CHAR_CLOSE);
      default: while (expr_buf.size() > idx + 1) expr_buf.delete(expr_buf.size() - 1);
    endcase
  endtask

  // ------------------------------------------------------------------
  // receiver side and checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    postfix_item_t want;
    if (expected_postfix.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, token %0h",
                                postfix_out.token));
    end else begin
      want = expected_postfix.pop_front();
      if (postfix_out.token_present !== want.token_present)
        report_mismatch($sformatf("token_present %b, expected %b",
                                  postfix_out.token_present, want.token_present));
      if (postfix_out.token !== want.token)
        report_mismatch($sformatf("token %h, expected %h", postfix_out.token, want.token));
      if (postfix_out.end_of_result !== want.end_of_result)
        report_mismatch($sformatf("end_of_result %b, expected %b",
                                  postfix_out.end_of_result, want.end_of_result));
      if (postfix_out.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d",
                                  postfix_out.status, want.status));
    end
  endtask

  // checks each output transfer, then draws ready for the next cycle
  initial begin
    postfix_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && postfix_out.valid && postfix_out.ready) check_result();
      postfix_out.ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted here cycle by cycle
  initial begin
    forever begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // watchdog: too long without a transfer on either channel ends the run
  initial begin
    int quiet;
    quiet = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if ((expr_in.valid && expr_in.ready) || (postfix_out.valid && postfix_out.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // precedence, equal precedence popping, parentheses and both letter cases
  task automatic test_precedence();
    send_text("a+b*c-d/e");
    send_text("(A)/z");
  endtask

  // lone spaces make an empty but valid expression
  task automatic test_spaces();
    send_text(" ");
    send_text("Q ");
  endtask

  task automatic test_invalid_input();
    send_char(8'h00, 1'b1);       // not a symbol at all
    send_char(8'hFF, 1'b1);
    send_text(")");               // close with nothing open
    send_text("ab+c");            // first error wins, later tokens dropped
    send_text("+");               // operator cannot open an expression
    send_text("()");              // empty parentheses
    send_text("(");               // left open at the end
    send_text("a*");              // ends on an operator
  endtask

  // a full stack refuses both another open paren and an operator
  task automatic test_stack_overflow();
    repeat (DEPTH + 1) send_char(itpc_pkg::CHAR_OPEN, 1'b0);
    send_text("a");
    repeat (DEPTH) send_char(itpc_pkg::CHAR_OPEN, 1'b0);
    send_text("a+b");
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_start;
    send_text("a*b+c*d-e/f+g*h-i/j+k*l-m/n+o");
    repeat (4) begin
      expr_buf.delete();
      build_sum(2);
      send_buffer();
    end
  endtask

  // mostly well-formed expressions, the rest broken ones and raw noise
  task automatic test_random_phase(input int item_budget);
    int stop_at;
    int pick;
    stop_at = chars_sent + item_budget;
    while (chars_sent < stop_at) begin
      pick = $urandom_range(99);
      expr_buf.delete();
      if (pick < 10) begin
        repeat ($urandom_range(4, 1)) expr_buf.push_back(8'($urandom_range(255)));
      end else begin
        build_sum($urandom_range(3));
        if (pick < 24) damage_expression();
      end
      send_buffer();
    end
  endtask

  initial begin
    expr_in.valid             = 1'b0;
    expr_in.character         = 8'h00;
    expr_in.end_of_expression = 1'b0;
    rst                       = 1'b1;
    send_idle_pct             = 19;
    recv_idle_pct             = 61;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_precedence();
    test_spaces();
    test_invalid_input();
    test_stack_overflow();
    test_random_phase(45);

    send_idle_pct = 61;
    recv_idle_pct = 19;
    test_random_phase(45);

    test_backpressure();
    test_random_phase(45);

    // stop offering, then wait for the last closing result to come out
    expr_in.valid <= 1'b0;
    while (expected_postfix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_postfix.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/itpc_pkg.sv
rtl/itpc_if.sv
rtl/itpc_ram.sv
rtl/itpc_ctrl.sv
rtl/itpc_datapath.sv
rtl/infix_to_postfix_converter_unit.sv
tb/infix_to_postfix_converter_unit_tb.sv
